FILE: src/cihs_pkg.sv
// Shared types and constants for the CBOR item head serializer.
package cihs_pkg;

    // Operation codes carried by an input request
    typedef enum logic [1:0] {
        OP_HEAD   = 2'd0,
        OP_SIGNED = 2'd1,
        OP_RAW    = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    // Additional info codes for heads with trailing argument bytes
    localparam logic [4:0] AI_ARG8  = 5'd24;
    localparam logic [4:0] AI_ARG16 = 5'd25;
    localparam logic [4:0] AI_ARG32 = 5'd26;
    localparam logic [4:0] AI_ARG64 = 5'd27;

    // Largest argument that fits directly in the lead byte, plus one
    localparam logic [63:0] ARG_IMM_LIMIT = 64'd24;

    localparam logic [31:0] SIZE_MAX = 32'hffff_ffff;

    // Default depth of the command queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    // Input request
    typedef struct packed {
        t_op                operation;
        logic        [2:0]  major_type;
        logic        [63:0] argument;
        logic signed [63:0] signed_value;
        logic        [7:0]  payload_byte;
    } t_in_req;

    // Output request
    typedef struct packed {
        logic [7:0]  out_byte;
        logic [31:0] byte_offset;
        logic        in_buffer;
        logic        last;
    } t_out_req;

    // Classified command: lead byte, argument bytes left-aligned, count of them
    typedef struct packed {
        logic [7:0]  lead;
        logic [63:0] arg_aligned;
        logic [3:0]  nargs;
    } t_cmd;

endpackage

FILE: src/cbor_item_head_serializer.sv
// Top level of the CBOR item head serializer: front, command queue, back.
//
//  channel  direction  handshake                  payload
//  in       input      i_in_valid / o_in_ready    i_in_req  (t_in_req)
//  out      output     o_out_valid / i_out_ready  o_out_req (t_out_req)
//  cfg      input      i_cfg_we                   i_cfg_wdata (buffer capacity)
//
// The back stage emits one byte per cycle while the output is ready, so raw
// payload bytes and single-byte heads sustain one request per cycle; a head
// with N argument bytes holds the back stage for N+1 bytes while front and
// queue accept until it fills; inputs pass front, queue and back registers.
// Reset is synchronous and clears the byte count, capacity and all valids.
// Either side may stall independently; the queue absorbs the difference.
module cbor_item_head_serializer
    import cihs_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_req     i_in_req,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_req    o_out_req
);

    logic f_valid;
    logic f_ready;
    t_cmd f_cmd;
    logic q_valid;
    logic q_ready;
    t_cmd q_cmd;

    cihs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_cmd_valid (f_valid),
        .i_cmd_ready (f_ready),
        .o_cmd       (f_cmd)
    );

    cihs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push_cmd   (f_cmd),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_cmd    (q_cmd)
    );

    cihs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd_valid (q_valid),
        .o_cmd_ready (q_ready),
        .i_cmd       (q_cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_req   (o_out_req)
    );

endmodule

FILE: src/cihs_front.sv
// Front stage: accepts input requests and classifies them into byte commands.
module cihs_front
    import cihs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_in_req i_in_req,
    output logic    o_cmd_valid,
    input  logic    i_cmd_ready,
    output t_cmd    o_cmd
);

    logic        r_valid;
    logic        n_valid;
    t_cmd        r_cmd;
    t_cmd        n_cmd;
    logic        accept;
    logic [63:0] arg;
    logic [2:0]  major;
    logic        drop;

    assign o_in_ready  = !r_valid || i_cmd_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    // Pick major type and argument per operation
    always_comb begin
        arg   = i_in_req.argument;
        major = i_in_req.major_type;
        drop  = 1'b0;
        unique case (i_in_req.operation)
            OP_HEAD: begin
                arg   = i_in_req.argument;
                major = i_in_req.major_type;
            end
            OP_SIGNED: begin
                if (i_in_req.signed_value[63]) begin
                    arg   = ~i_in_req.signed_value;
                    major = 3'd1;
                end else begin
                    arg   = i_in_req.signed_value;
                    major = 3'd0;
                end
            end
            OP_RAW: begin
                arg   = i_in_req.argument;
                major = i_in_req.major_type;
            end
            default: drop = 1'b1;
        endcase
    end

    // Size class and lead byte; argument bytes left-aligned for the back end
    always_comb begin
        n_cmd.arg_aligned = arg;
        if (i_in_req.operation == OP_RAW) begin
            n_cmd.lead  = i_in_req.payload_byte;
            n_cmd.nargs = 4'd0;
        end else if (arg < ARG_IMM_LIMIT) begin
            n_cmd.lead  = {major, arg[4:0]};
            n_cmd.nargs = 4'd0;
        end else if (arg[63:8] == 56'd0) begin
            n_cmd.lead        = {major, AI_ARG8};
            n_cmd.nargs       = 4'd1;
            n_cmd.arg_aligned = {arg[7:0], 56'd0};
        end else if (arg[63:16] == 48'd0) begin
            n_cmd.lead        = {major, AI_ARG16};
            n_cmd.nargs       = 4'd2;
            n_cmd.arg_aligned = {arg[15:0], 48'd0};
        end else if (arg[63:32] == 32'd0) begin
            n_cmd.lead        = {major, AI_ARG32};
            n_cmd.nargs       = 4'd4;
            n_cmd.arg_aligned = {arg[31:0], 32'd0};
        end else begin
            n_cmd.lead  = {major, AI_ARG64};
            n_cmd.nargs = 4'd8;
        end
    end

    // Valid flag: unused operation codes are consumed without a command
    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = !drop;
        end else if (i_cmd_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

FILE: src/cihs_queue.sv
// Short command queue decoupling the front and back stages.
module cihs_queue
    import cihs_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_cmd i_push_cmd,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_cmd o_pop_cmd
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [AW:0]   FULL_CNT = (AW + 1)'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wptr;
    logic [AW-1:0] r_rptr;
    logic [AW:0]   r_count;
    logic [AW-1:0] n_wptr;
    logic [AW-1:0] n_rptr;
    logic [AW:0]   n_count;
    logic          push;
    logic          pop;

    assign o_push_ready = (r_count != FULL_CNT);
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cmd    = r_mem[r_rptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Pointer wrap and occupancy
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (push) begin
            n_wptr = (r_wptr == LAST_PTR) ? '0 : r_wptr + 1'b1;
        end
        if (pop) begin
            n_rptr = (r_rptr == LAST_PTR) ? '0 : r_rptr + 1'b1;
        end
        case ({push, pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_push_cmd;
        end
    end

endmodule

FILE: src/cihs_back.sv
// Back stage: serializes commands into bytes with offset and buffer flags.
module cihs_back
    import cihs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_cmd_valid,
    output logic        o_cmd_ready,
    input  t_cmd        i_cmd,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_req    o_out_req
);

    logic [15:0] r_capacity;
    logic [31:0] r_size;
    logic [31:0] n_size;
    logic        r_busy;
    logic        n_busy;
    logic [3:0]  r_idx;
    logic [3:0]  n_idx;
    logic [3:0]  r_nargs;
    logic [3:0]  n_nargs;
    logic [63:0] r_shift;
    logic [63:0] n_shift;
    logic        r_out_valid;
    logic        n_out_valid;
    t_out_req    r_out;
    t_out_req    n_out;
    logic        advance;
    logic        emit;

    assign advance     = !r_out_valid || i_out_ready;
    assign o_cmd_ready = advance && !r_busy;
    assign emit        = advance && (r_busy || i_cmd_valid);
    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

    // Byte sequencing: lead byte from the queue, then argument bytes MSB first
    always_comb begin
        n_busy        = r_busy;
        n_idx         = r_idx;
        n_nargs       = r_nargs;
        n_shift       = r_shift;
        n_out         = r_out;
        n_out_valid   = r_out_valid && !i_out_ready;
        if (emit) begin
            n_out_valid       = 1'b1;
            n_out.byte_offset = r_size;
            n_out.in_buffer   = (r_size < {16'd0, r_capacity});
            if (r_busy) begin
                n_out.out_byte = r_shift[63:56];
                n_out.last     = (r_idx == r_nargs);
                n_shift        = {r_shift[55:0], 8'd0};
                n_idx          = r_idx + 1'b1;
                n_busy         = (r_idx != r_nargs);
            end else begin
                n_out.out_byte = i_cmd.lead;
                n_out.last     = (i_cmd.nargs == 4'd0);
                n_shift        = i_cmd.arg_aligned;
                n_nargs        = i_cmd.nargs;
                n_idx          = 4'd1;
                n_busy         = (i_cmd.nargs != 4'd0);
            end
        end
    end

    // Saturating byte count
    always_comb begin
        n_size = r_size;
        if (emit && (r_size != SIZE_MAX)) begin
            n_size = r_size + 32'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= 16'd0;
            r_size      <= 32'd0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_wdata;
            end
            r_size      <= n_size;
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_nargs <= n_nargs;
        r_shift <= n_shift;
        r_out   <= n_out;
    end

endmodule
